/* rtl/utf8d_pkg.sv */
package utf8d_pkg;

  // Field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned RemW  = 3;
  localparam int unsigned ContW = 6;

  // Longest sequence: five continuation words after the lead word
  localparam logic [RemW-1:0] MaxCont = RemW'(5);
  localparam logic [RemW-1:0] RemNone = '0;

  // One result word as it travels to the output
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           bad_lead;
    logic           truncated;
    logic           last_result;
  } res_t;

endpackage

/* rtl/utf8d_step.sv */
module utf8d_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [utf8d_pkg::ByteW-1:0]   in_byte_i,
  input  logic                          end_of_string_i,
  output logic                          res_valid_o,
  output utf8d_pkg::res_t               res_o
);

  logic [utf8d_pkg::CpW-1:0]  part_q, part_d;
  logic [utf8d_pkg::RemW-1:0] rem_q, rem_d;
  logic [utf8d_pkg::CpW-1:0]  shifted;
  logic                       seq_open;
  logic                       emit;
  utf8d_pkg::res_t            res;

  assign shifted = {part_q[utf8d_pkg::CpW-utf8d_pkg::ContW-1:0],
                    in_byte_i[utf8d_pkg::ContW-1:0]};

  // Decode one word against the current sequence state
  always_comb begin
    part_d               = part_q;
    rem_d                = rem_q;
    seq_open             = 1'b0;
    emit                 = 1'b0;
    res.code_point       = '0;
    res.bad_lead         = 1'b0;
    res.truncated        = 1'b0;
    res.last_result      = end_of_string_i;

    if (rem_q == utf8d_pkg::RemNone) begin
      unique casez (in_byte_i)
        8'b0???????: begin
          emit           = 1'b1;
          res.code_point = utf8d_pkg::CpW'(in_byte_i);
        end
        8'b110?????: begin
          part_d   = utf8d_pkg::CpW'(in_byte_i[4:0]);
          rem_d    = utf8d_pkg::RemW'(1);
          seq_open = 1'b1;
        end
        8'b1110????: begin
          part_d   = utf8d_pkg::CpW'(in_byte_i[3:0]);
          rem_d    = utf8d_pkg::RemW'(2);
          seq_open = 1'b1;
        end
        8'b11110???: begin
          part_d   = utf8d_pkg::CpW'(in_byte_i[2:0]);
          rem_d    = utf8d_pkg::RemW'(3);
          seq_open = 1'b1;
        end
        8'b111110??: begin
          part_d   = utf8d_pkg::CpW'(in_byte_i[1:0]);
          rem_d    = utf8d_pkg::RemW'(4);
          seq_open = 1'b1;
        end
        8'b1111110?: begin
          part_d   = utf8d_pkg::CpW'(in_byte_i[0]);
          rem_d    = utf8d_pkg::MaxCont;
          seq_open = 1'b1;
        end
        default: begin
          // stray continuation or 0xFE/0xFF where a lead is due
          emit         = 1'b1;
          res.bad_lead = 1'b1;
        end
      endcase
    end else begin
      // shift in six payload bits, continuation pattern is not checked
      rem_d = rem_q - utf8d_pkg::RemW'(1);
      if (rem_d == utf8d_pkg::RemNone) begin
        emit           = 1'b1;
        res.code_point = shifted;
        part_d         = '0;
      end else begin
        part_d   = shifted;
        seq_open = 1'b1;
      end
    end

    // drop an open sequence when the string ends
    if (seq_open && end_of_string_i) begin
      part_d          = '0;
      rem_d           = utf8d_pkg::RemNone;
      emit            = 1'b1;
      res.truncated   = 1'b1;
      res.last_result = 1'b1;
    end
  end

  // Advance the sequence state on each consumed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      rem_q  <= utf8d_pkg::RemNone;
    end else if (fire_i) begin
      part_q <= part_d;
      rem_q  <= rem_d;
    end
  end

  assign res_valid_o = fire_i && emit;
  assign res_o       = res;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= utf8d_pkg::MaxCont)
    else $error("continuation count out of range");

  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.truncated |-> res_o.last_result && (res_o.code_point == '0))
    else $error("truncation result without end flag or with payload");

  a_trunc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.truncated |=> rem_q == utf8d_pkg::RemNone)
    else $error("sequence state not cleared after truncation");

endmodule

/* rtl/utf8d_out_buf.sv */
module utf8d_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  utf8d_pkg::res_t push_data_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output utf8d_pkg::res_t out_data_o
);

  logic            out_valid_q, out_valid_d;
  logic            skid_valid_q, skid_valid_d;
  utf8d_pkg::res_t out_q, out_d;
  utf8d_pkg::res_t skid_q, skid_d;
  logic            pop;

  assign pop = out_valid_q && !out_stall_i;

  // Hold a result in the skid word when the output is stalled
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && skid_valid_q))
    else $error("result pushed into full buffer");

endmodule

/* rtl/utf8_stream_decoder.sv */
// Byte-serial UTF-8 decoder for the original one- to six-byte form. It takes
// one byte per clock while in_stall_o is low, and gives one result word per
// completed code point, per byte that cannot lead a sequence (bad_lead, code
// point zero), and per end-of-string flag met inside a sequence (truncated,
// code point zero); the result for the end-of-string byte carries last_result.
// Continuation bytes are not checked, only their low six bits are used. The
// sustained rate is one byte per cycle while the output is not stalled; each
// byte is registered before decoding, each result in the output buffer. The
// rate is set by the sequence state loop (count and partial value). A
// two-word output buffer absorbs an output stall until in_stall_o rises.
module utf8_stream_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [utf8d_pkg::ByteW-1:0]         in_byte_i,
  input  logic                                end_of_string_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [utf8d_pkg::CpW-1:0]           code_point_o,
  output logic                                bad_lead_o,
  output logic                                truncated_o,
  output logic                                last_result_o
);

  logic                          in_valid_q;
  logic [utf8d_pkg::ByteW-1:0]   byte_q;
  logic                          eos_q;
  logic                          accept;
  logic                          fire;
  logic                          buf_full;
  logic                          res_valid;
  utf8d_pkg::res_t               res;
  utf8d_pkg::res_t               out_data;

  assign in_stall_o = in_valid_q && buf_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = in_valid_q && !buf_full;

  // Register the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
      eos_q  <= end_of_string_i;
    end
  end

  utf8d_step u_step (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .in_byte_i       (byte_q),
    .end_of_string_i (eos_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  utf8d_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign code_point_o  = out_data.code_point;
  assign bad_lead_o    = out_data.bad_lead;
  assign truncated_o   = out_data.truncated;
  assign last_result_o = out_data.last_result;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned IdlePct    = 27;

  typedef enum logic {
    PACE_RANDOM,
    PACE_STEADY
  } pace_e;

  typedef struct packed {
    logic [utf8d_pkg::ByteW-1:0] data;
    logic                        last;
  } stream_byte_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           in_valid_i      = 1'b0;
  logic                           in_stall_o;
  logic [utf8d_pkg::ByteW-1:0]    in_byte_i       = '0;
  logic                           end_of_string_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i     = 1'b0;
  logic [utf8d_pkg::CpW-1:0]      code_point_o;
  logic                           bad_lead_o;
  logic                           truncated_o;
  logic                           last_result_o;

  // Stimulus and expectation stores
  stream_byte_t     byte_q[$];
  utf8d_pkg::res_t  decoded_q[$];

  // Decoder state as predicted
  logic [utf8d_pkg::CpW-1:0]  seq_value = '0;
  logic [utf8d_pkg::RemW-1:0] seq_left  = utf8d_pkg::RemNone;

  pace_e       pace          = PACE_RANDOM;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  int unsigned words_offered = 0;
  int unsigned words_taken   = 0;
  int unsigned bytes_queued  = 0;
  int unsigned cycles        = 0;
  int unsigned errors        = 0;
  int unsigned n_chars       = 0;
  int unsigned n_bad         = 0;
  int unsigned n_trunc       = 0;
  int unsigned n_last        = 0;
  int unsigned n_in_held     = 0;

  utf8_stream_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_point_o    (code_point_o),
    .bad_lead_o      (bad_lead_o),
    .truncated_o     (truncated_o),
    .last_result_o   (last_result_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    errors++;
  endtask

  // Advance the predicted decoder by one byte, queue the word it yields
  task automatic decode_byte(input logic [utf8d_pkg::ByteW-1:0] b, input logic eos);
    utf8d_pkg::res_t r;
    bit              gives;
    r     = '0;
    gives = 1'b0;
    if (seq_left == utf8d_pkg::RemNone) begin
      casez (b)
        8'b0???????: begin
          r.code_point = utf8d_pkg::CpW'(b);
          gives        = 1'b1;
        end
        8'b110?????: begin
          seq_value = utf8d_pkg::CpW'(b[4:0]);
          seq_left  = utf8d_pkg::RemW'(1);
        end
        8'b1110????: begin
          seq_value = utf8d_pkg::CpW'(b[3:0]);
          seq_left  = utf8d_pkg::RemW'(2);
        end
        8'b11110???: begin
          seq_value = utf8d_pkg::CpW'(b[2:0]);
          seq_left  = utf8d_pkg::RemW'(3);
        end
        8'b111110??: begin
          seq_value = utf8d_pkg::CpW'(b[1:0]);
          seq_left  = utf8d_pkg::RemW'(4);
        end
        8'b1111110?: begin
          seq_value = utf8d_pkg::CpW'(b[0]);
          seq_left  = utf8d_pkg::MaxCont;
        end
        default: begin
          r.bad_lead = 1'b1;
          gives      = 1'b1;
        end
      endcase
    end else begin
      seq_value = {seq_value[utf8d_pkg::CpW-utf8d_pkg::ContW-1:0],
                   b[utf8d_pkg::ContW-1:0]};
      seq_left  = seq_left - utf8d_pkg::RemW'(1);
      if (seq_left == utf8d_pkg::RemNone) begin
        r.code_point = seq_value;
        seq_value    = '0;
        gives        = 1'b1;
      end
    end
    if (gives) begin
      r.last_result = eos;
      decoded_q     = {decoded_q, r};
    end else if (eos) begin
      // string ended inside a sequence: drop the partial value
      seq_value     = '0;
      seq_left      = utf8d_pkg::RemNone;
      r.truncated   = 1'b1;
      r.last_result = 1'b1;
      decoded_q     = {decoded_q, r};
    end
  endtask

  // Check result words, then predict from the word taken at this edge
  always @(posedge clk_i) begin
    utf8d_pkg::res_t exp_w;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) n_in_held++;
      if (out_valid_o && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result cp=%0h", code_point_o));
        end else begin
          exp_w = decoded_q.pop_front();
          if (code_point_o !== exp_w.code_point)
            report_mismatch($sformatf("code_point %0h, expected %0h",
                                      code_point_o, exp_w.code_point));
          if (bad_lead_o !== exp_w.bad_lead)
            report_mismatch($sformatf("bad_lead %b, expected %b",
                                      bad_lead_o, exp_w.bad_lead));
          if (truncated_o !== exp_w.truncated)
            report_mismatch($sformatf("truncated %b, expected %b",
                                      truncated_o, exp_w.truncated));
          if (last_result_o !== exp_w.last_result)
            report_mismatch($sformatf("last_result %b, expected %b",
                                      last_result_o, exp_w.last_result));
          if (exp_w.bad_lead) n_bad++;
          else if (exp_w.truncated) n_trunc++;
          else n_chars++;
          if (exp_w.last_result) n_last++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        words_taken++;
        decode_byte(in_byte_i, end_of_string_i);
      end
    end
  end

  // Drive the next byte once the current one is taken, idle at random
  always @(negedge clk_i) begin
    stream_byte_t w;
    if (rst_ni && (!in_valid_i || words_taken == words_offered)) begin
      if (byte_q.size() != 0 &&
          !(pace == PACE_RANDOM && $urandom_range(0, 99) < IdlePct)) begin
        w = byte_q.pop_front();
        words_offered++;
        in_byte_i       <= w.data;
        end_of_string_i <= w.last;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result side at random, or hold off for a counted stretch
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (pace == PACE_RANDOM) && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, decoded_q.size());
      $display("utf8_stream_decoder: mismatch");
      $finish;
    end
  end

  task automatic push_byte(input logic [utf8d_pkg::ByteW-1:0] value, input logic last);
    stream_byte_t w;
    w.data = value;
    w.last = last;
    byte_q = {byte_q, w};
    bytes_queued++;
  endtask

  // Queue the first keep bytes of a len-byte sequence with random payload
  task automatic push_char(input int unsigned len, input int unsigned keep,
                           input logic last);
    logic [utf8d_pkg::ByteW-1:0] b;
    case (len)
      1:       b = {1'b0, 7'($urandom)};
      2:       b = {3'b110, 5'($urandom)};
      3:       b = {4'b1110, 4'($urandom)};
      4:       b = {5'b11110, 3'($urandom)};
      5:       b = {6'b111110, 2'($urandom)};
      default: b = {7'b1111110, 1'($urandom)};
    endcase
    push_byte(b, last && keep == 1);
    for (int unsigned k = 1; k < keep; k++) begin
      // continuation bytes are not checked, so some carry any pattern
      b = ($urandom_range(0, 99) < 85) ? {2'b10, 6'($urandom)} : 8'($urandom);
      push_byte(b, last && k == keep - 1);
    end
  endtask

  // One string: mostly well-formed characters, some strays and truncations
  task automatic push_string();
    int unsigned n, r, len, keep;
    logic        last;
    n = $urandom_range(1, 12);
    if ($urandom_range(0, 99) < 8) begin
      for (int unsigned i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        last = (i == n - 1);
        r    = $urandom_range(0, 99);
        if (r < 4) begin
          case ($urandom_range(0, 2))
            0:       push_byte({2'b10, 6'($urandom)}, last);
            1:       push_byte(8'hFE, last);
            default: push_byte(8'hFF, last);
          endcase
        end else begin
          len  = (r < 45) ? 1 : (r < 65) ? 2 : (r < 78) ? 3 :
                 (r < 88) ? 4 : (r < 94) ? 5 : 6;
          keep = len;
          if (last && len > 1 && $urandom_range(0, 99) < 15)
            keep = $urandom_range(1, len - 1);
          push_char(len, keep, last);
        end
      end
    end
  endtask

  // Hold the sender until every queued byte is taken and every word is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (!(byte_q.size() == 0 && words_taken == words_offered &&
             decoded_q.size() == 0));
  endtask

  initial begin
    int unsigned goal;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, every length, strays, end inside a sequence
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'hDF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hE0, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hF4, 1'b0); push_byte(8'h8F, 1'b0);
    push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b1);
    push_byte(8'hFB, 1'b0);
    repeat (4) push_byte(8'hFF, 1'b0);
    push_byte(8'hFD, 1'b0);
    repeat (5) push_byte(8'hBF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hE2, 1'b1);
    wait_drained();

    // Random strings with idling on both sides
    goal = bytes_queued + 350;
    while (bytes_queued < goal) push_string();
    wait_drained();

    // Back-to-back traffic with no idling at all
    pace <= PACE_STEADY;
    goal = bytes_queued + 300;
    while (bytes_queued < goal) push_string();
    wait_drained();

    // Receiver holds off while the sender keeps offering single-byte chars
    hold_requests <= hold_requests + 1;
    @(negedge clk_i);
    @(negedge clk_i);
    for (int unsigned i = 0; i < 40; i++) push_byte({1'b0, 7'($urandom)}, i == 39);
    wait_drained();

    pace <= PACE_RANDOM;
    goal = bytes_queued + 350;
    while (bytes_queued < goal) push_string();
    wait_drained();
    repeat (8) @(negedge clk_i);

    $display("sent %0d bytes; checked %0d code points, %0d stray leads, %0d truncations",
             words_taken, n_chars, n_bad, n_trunc);
    $display("%0d strings ended, decoder held its input off on %0d cycles",
             n_last, n_in_held);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("utf8_stream_decoder: match");
    end else begin
      $display("utf8_stream_decoder: mismatch");
    end
    $finish;
  end

endmodule
